// File: rtl/prioritized_vector_sum_limit_defines.svh
// ============================================================================
// Assertion macros for the prioritized vector sum block
// Shared property wrappers, clocked on clk_i and disabled while rst_ni is low.
// ============================================================================
`ifndef PRIORITIZED_VECTOR_SUM_LIMIT_DEFINES_SVH
`define PRIORITIZED_VECTOR_SUM_LIMIT_DEFINES_SVH

// Same-cycle implication.
`define PVSL_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PVSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pvsl_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Prioritized vector sum package
// Shared constants, case codes and item structs.
// ============================================================================
package pvsl_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int unsigned FracBitsDef = 16;

  // Which rule produced a result.
  typedef enum logic [2:0] {
    CaseSumFits     = 3'd0,
    CasePrioExceeds = 3'd1,
    CaseEqual       = 3'd2,
    CaseAddZero     = 3'd3,
    CaseScaled      = 3'd4
  } case_e;

  // One input item.
  typedef struct packed {
    logic signed [31:0] prio_x;
    logic signed [31:0] prio_y;
    logic signed [31:0] add_x;
    logic signed [31:0] add_y;
    logic [30:0]        limit;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    case_e              case_taken;
  } res_t;

endpackage

// File: rtl/pvsl_intf.sv
`timescale 1ns / 1ps
// ============================================================================
// Prioritized vector sum channels
// Valid/ready channel interfaces for input and result items.
// ============================================================================

// Input item channel.
interface pvsl_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] prio_x;
  logic signed [31:0] prio_y;
  logic signed [31:0] add_x;
  logic signed [31:0] add_y;
  logic [30:0]        limit;

  modport source (output valid, prio_x, prio_y, add_x, add_y, limit, input ready);
  modport sink   (input valid, prio_x, prio_y, add_x, add_y, limit, output ready);
endinterface

// Result item channel.
interface pvsl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic [2:0]         case_taken;

  modport source (output valid, out_x, out_y, case_taken, input ready);
  modport sink   (input valid, out_x, out_y, case_taken, output ready);
endinterface

// File: rtl/pvsl_datapath.sv
`timescale 1ns / 1ps
`include "prioritized_vector_sum_limit_defines.svh"
// ============================================================================
// Prioritized vector sum datapath
// Fully pipelined arithmetic: products, case decision, two square roots and
// two restoring dividers, one bit per stage, under a common stage enable.
// ============================================================================
module pvsl_datapath #(
  parameter int unsigned FracBits = pvsl_pkg::FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  pvsl_pkg::in_item_t item_i,
  output logic              valid_o,
  output pvsl_pkg::res_t    res_o
);
  import pvsl_pkg::*;

  // Threshold of 0.001, rounded up in raw units.
  localparam int unsigned Eps      = ((32'd1 << FracBits) + 32'd999) / 32'd1000;
  localparam logic [32:0] EpsW     = 33'(Eps);
  localparam logic [62:0] Eps2     = 63'(Eps * Eps);

  localparam int unsigned SqSteps   = 32;
  localparam int unsigned Div1Steps = 34;
  localparam int unsigned Div2Steps = 35;
  localparam int unsigned NumW      = 66;

  localparam int unsigned IdxP1  = 2 + (SqSteps + 1) + (Div1Steps + 1);
  localparam int unsigned IdxP4  = IdxP1 + 2 + (SqSteps + 1);
  localparam int unsigned IdxD2L = IdxP4 + 2 + Div2Steps;
  localparam int unsigned Depth  = IdxD2L + 2;

  // Data carried alongside the arithmetic units.
  typedef struct packed {
    case_e              kase;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [61:0]        lim2;
    logic [31:0]        root;
  } side_t;

  typedef struct packed {
    logic signed [31:0] px, py, ax, ay;
    logic [30:0]        lim;
    logic signed [32:0] sx, sy, dx, dy;
  } r1_t;

  typedef struct packed {
    logic signed [31:0] px, py, ax, ay;
    logic signed [32:0] sx, sy;
    logic [63:0]        psq_x, psq_y, asq_x, asq_y;
    logic [61:0]        ssq_x, ssq_y, dsq_x, dsq_y, lim2;
    logic signed [63:0] cr_a, cr_b, dt_a, dt_b;
    logic [62:0]        plx, ply;
    logic               s_in, d_in;
  } r2_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sqc_t;

  typedef struct packed {
    side_t       sd;
    logic [63:0] opx, opy;
    logic        negx, negy;
  } sq1s_t;

  typedef struct packed {
    logic [NumW-1:0] num;
    logic [31:0]     rem;
    logic [34:0]     q;
  } dvl_t;

  typedef struct packed {
    side_t sd;
    logic  negx, negy;
  } d1s_t;

  typedef struct packed {
    side_t              sd;
    logic [34:0]        cmag;
    logic signed [35:0] b;
  } p1_t;

  typedef struct packed {
    side_t              sd;
    logic [63:0]        c2;
    logic signed [35:0] b;
  } p2_t;

  typedef struct packed {
    side_t              sd;
    logic signed [35:0] b;
    logic               neg;
  } sq2s_t;

  typedef struct packed {
    side_t       sd;
    logic [33:0] s;
  } p4_t;

  typedef struct packed {
    side_t       sd;
    logic [65:0] prod_x, prod_y;
  } p5_t;

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [32:0] mag33(logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return signed'(v[31:0]);
    end
  endfunction

  // One digit of the bit-pair square root.
  function automatic sqc_t sq_step(sqc_t s);
    sqc_t        o;
    logic [35:0] t;
    logic [35:0] trial;
    t       = {s.rem, s.rad[63:62]};
    trial   = {2'b00, s.root, 2'b01};
    o.rad   = {s.rad[61:0], 2'b00};
    if (t >= trial) begin
      o.rem  = 34'(t - trial);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = 34'(t);
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  // One quotient bit of restoring division.
  function automatic dvl_t dv_step(dvl_t l, logic [31:0] den);
    dvl_t        o;
    logic [32:0] t;
    t     = {l.rem, l.num[NumW-1]};
    o.num = {l.num[NumW-2:0], 1'b0};
    if (t >= {1'b0, den}) begin
      o.rem = 32'(t - {1'b0, den});
      o.q   = {l.q[33:0], 1'b1};
    end else begin
      o.rem = t[31:0];
      o.q   = {l.q[33:0], 1'b0};
    end
    return o;
  endfunction

  // Valid bits, one per stage.
  logic [Depth-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[Depth-1];

  // Stage 1: register the item with its sum and difference.
  r1_t r1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q.px  <= item_i.prio_x;
      r1_q.py  <= item_i.prio_y;
      r1_q.ax  <= item_i.add_x;
      r1_q.ay  <= item_i.add_y;
      r1_q.lim <= item_i.limit;
      r1_q.sx  <= 33'(item_i.prio_x) + 33'(item_i.add_x);
      r1_q.sy  <= 33'(item_i.prio_y) + 33'(item_i.add_y);
      r1_q.dx  <= 33'(item_i.add_x) - 33'(item_i.prio_x);
      r1_q.dy  <= 33'(item_i.add_y) - 33'(item_i.prio_y);
    end
  end

  // Stage 2: all squares and cross products in parallel.
  r2_t         r2_d, r2_q;
  logic [31:0] m_px, m_py, m_ax, m_ay;
  logic [30:0] m_sx, m_sy, m_dx, m_dy;

  always_comb begin
    m_px = mag32(r1_q.px);
    m_py = mag32(r1_q.py);
    m_ax = mag32(r1_q.ax);
    m_ay = mag32(r1_q.ay);
    m_sx = 31'(mag33(r1_q.sx));
    m_sy = 31'(mag33(r1_q.sy));
    m_dx = 31'(mag33(r1_q.dx));
    m_dy = 31'(mag33(r1_q.dy));
    r2_d.px    = r1_q.px;
    r2_d.py    = r1_q.py;
    r2_d.ax    = r1_q.ax;
    r2_d.ay    = r1_q.ay;
    r2_d.sx    = r1_q.sx;
    r2_d.sy    = r1_q.sy;
    r2_d.psq_x = 64'(m_px) * 64'(m_px);
    r2_d.psq_y = 64'(m_py) * 64'(m_py);
    r2_d.asq_x = 64'(m_ax) * 64'(m_ax);
    r2_d.asq_y = 64'(m_ay) * 64'(m_ay);
    r2_d.ssq_x = 62'(m_sx) * 62'(m_sx);
    r2_d.ssq_y = 62'(m_sy) * 62'(m_sy);
    r2_d.dsq_x = 62'(m_dx) * 62'(m_dx);
    r2_d.dsq_y = 62'(m_dy) * 62'(m_dy);
    r2_d.lim2  = 62'(r1_q.lim) * 62'(r1_q.lim);
    r2_d.cr_a  = 64'(r1_q.px) * 64'(r1_q.ay);
    r2_d.cr_b  = 64'(r1_q.py) * 64'(r1_q.ax);
    r2_d.dt_a  = 64'(r1_q.px) * 64'(r1_q.ax);
    r2_d.dt_b  = 64'(r1_q.py) * 64'(r1_q.ay);
    r2_d.plx   = 63'(m_px) * 63'(r1_q.lim);
    r2_d.ply   = 63'(m_py) * 63'(r1_q.lim);
    r2_d.s_in  = (mag33(r1_q.sx) <= {2'b00, r1_q.lim}) &&
                 (mag33(r1_q.sy) <= {2'b00, r1_q.lim});
    r2_d.d_in  = (mag33(r1_q.dx) < EpsW) && (mag33(r1_q.dy) < EpsW);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r2_q <= r2_d;
    end
  end

  // Stage 3: sums, case decision and operand selection for the first root.
  logic [63:0]        p2, a2;
  logic [62:0]        s2, d2;
  logic signed [63:0] cr, dt;
  logic               k23;
  sqc_t               sq1c0_d;
  sq1s_t              sq1s0_d;

  always_comb begin
    p2 = r2_q.psq_x + r2_q.psq_y;
    a2 = r2_q.asq_x + r2_q.asq_y;
    s2 = 63'(r2_q.ssq_x) + 63'(r2_q.ssq_y);
    d2 = 63'(r2_q.dsq_x) + 63'(r2_q.dsq_y);
    cr = r2_q.cr_a - r2_q.cr_b;
    dt = r2_q.dt_a + r2_q.dt_b;
    if (r2_q.s_in && (s2 <= 63'(r2_q.lim2))) begin
      sq1s0_d.sd.kase = CaseSumFits;
    end else if (p2 >= 64'(r2_q.lim2)) begin
      sq1s0_d.sd.kase = CasePrioExceeds;
    end else if (r2_q.d_in && (d2 < Eps2)) begin
      sq1s0_d.sd.kase = CaseEqual;
    end else if (a2 < 64'(Eps2)) begin
      sq1s0_d.sd.kase = CaseAddZero;
    end else begin
      sq1s0_d.sd.kase = CaseScaled;
    end
    k23 = (sq1s0_d.sd.kase == CaseEqual) || (sq1s0_d.sd.kase == CaseAddZero);
    if (sq1s0_d.sd.kase == CaseSumFits) begin
      sq1s0_d.sd.base_x = sat32(36'(r2_q.sx));
      sq1s0_d.sd.base_y = sat32(36'(r2_q.sy));
    end else begin
      sq1s0_d.sd.base_x = r2_q.px;
      sq1s0_d.sd.base_y = r2_q.py;
    end
    sq1s0_d.sd.ax   = r2_q.ax;
    sq1s0_d.sd.ay   = r2_q.ay;
    sq1s0_d.sd.lim2 = r2_q.lim2;
    sq1s0_d.sd.root = '0;
    sq1s0_d.opx     = k23 ? {1'b0, r2_q.plx} : mag64(cr);
    sq1s0_d.opy     = k23 ? {1'b0, r2_q.ply} : mag64(dt);
    sq1s0_d.negx    = k23 ? r2_q.px[31] : cr[63];
    sq1s0_d.negy    = k23 ? r2_q.py[31] : dt[63];
    sq1c0_d.rad     = k23 ? p2 : a2;
    sq1c0_d.rem     = '0;
    sq1c0_d.root    = '0;
  end

  // First square root: length of the priority or the secondary vector.
  sqc_t  sq1_c_q [SqSteps+1];
  sq1s_t sq1_s_q [SqSteps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq1_c_q[0] <= sq1c0_d;
      sq1_s_q[0] <= sq1s0_d;
    end
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sq1
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq1_c_q[k+1] <= sq_step(sq1_c_q[k]);
        sq1_s_q[k+1] <= sq1_s_q[k];
      end
    end
  end

  // First divider: scale to the limit, or cross and dot over the norm.
  logic [31:0]     den1;
  logic [NumW-1:0] n1x, n1y;
  dvl_t            d1x0_d, d1y0_d;
  d1s_t            d1s0_d;

  always_comb begin
    den1 = (sq1_c_q[SqSteps].root == '0) ? 32'd1 : sq1_c_q[SqSteps].root;
    n1x  = {2'b00, sq1_s_q[SqSteps].opx};
    n1y  = {2'b00, sq1_s_q[SqSteps].opy};
    d1x0_d.rem = 32'(n1x >> Div1Steps);
    d1x0_d.num = n1x << (NumW - Div1Steps);
    d1x0_d.q   = '0;
    d1y0_d.rem = 32'(n1y >> Div1Steps);
    d1y0_d.num = n1y << (NumW - Div1Steps);
    d1y0_d.q   = '0;
    d1s0_d.sd      = sq1_s_q[SqSteps].sd;
    d1s0_d.sd.root = den1;
    d1s0_d.negx    = sq1_s_q[SqSteps].negx;
    d1s0_d.negy    = sq1_s_q[SqSteps].negy;
  end

  dvl_t d1x_q [Div1Steps+1];
  dvl_t d1y_q [Div1Steps+1];
  d1s_t d1s_q [Div1Steps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1x_q[0] <= d1x0_d;
      d1y_q[0] <= d1y0_d;
      d1s_q[0] <= d1s0_d;
    end
  end

  for (genvar k = 0; k < Div1Steps; k++) begin : g_div1
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d1x_q[k+1] <= dv_step(d1x_q[k], d1s_q[k].sd.root);
        d1y_q[k+1] <= dv_step(d1y_q[k], d1s_q[k].sd.root);
        d1s_q[k+1] <= d1s_q[k];
      end
    end
  end

  // Restore signs: final vector for the equal and add-zero cases, c and b otherwise.
  p1_t         p1_d, p1_q;
  logic [34:0] q1x, q1y;

  always_comb begin
    q1x = d1x_q[Div1Steps].q;
    q1y = d1y_q[Div1Steps].q;
    p1_d.sd   = d1s_q[Div1Steps].sd;
    p1_d.cmag = q1x;
    p1_d.b    = d1s_q[Div1Steps].negy ? -signed'(36'(q1y)) : signed'(36'(q1y));
    if ((p1_d.sd.kase == CaseEqual) || (p1_d.sd.kase == CaseAddZero)) begin
      p1_d.sd.base_x = d1s_q[Div1Steps].negx ? -signed'(32'(q1x)) : signed'(32'(q1x));
      p1_d.sd.base_y = d1s_q[Div1Steps].negy ? -signed'(32'(q1y)) : signed'(32'(q1y));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= p1_d;
    end
  end

  // Square of the cross term.
  p2_t p2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p2_q.sd <= p1_q.sd;
      p2_q.b  <= p1_q.b;
      p2_q.c2 <= 64'(p1_q.cmag[31:0]) * 64'(p1_q.cmag[31:0]);
    end
  end

  // Second square root on the limit squared less the cross term squared.
  sqc_t  sq2c0_d;
  sq2s_t sq2s0_d;

  always_comb begin
    sq2s0_d.sd   = p2_q.sd;
    sq2s0_d.b    = p2_q.b;
    sq2s0_d.neg  = p2_q.c2 > 64'(p2_q.sd.lim2);
    sq2c0_d.rad  = 64'(p2_q.sd.lim2) - p2_q.c2;
    sq2c0_d.rem  = '0;
    sq2c0_d.root = '0;
  end

  sqc_t  sq2_c_q [SqSteps+1];
  sq2s_t sq2_s_q [SqSteps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq2_c_q[0] <= sq2c0_d;
      sq2_s_q[0] <= sq2s0_d;
    end
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sq2
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq2_c_q[k+1] <= sq_step(sq2_c_q[k]);
        sq2_s_q[k+1] <= sq2_s_q[k];
      end
    end
  end

  // Step length along the secondary direction, clipped at zero.
  p4_t                p4_d, p4_q;
  logic signed [35:0] det_s;

  always_comb begin
    det_s     = signed'({4'b0000, sq2_c_q[SqSteps].root});
    p4_d.sd   = sq2_s_q[SqSteps].sd;
    if (!sq2_s_q[SqSteps].neg && (det_s >= sq2_s_q[SqSteps].b)) begin
      p4_d.s = 34'(det_s - sq2_s_q[SqSteps].b);
    end else begin
      p4_d.s = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p4_q <= p4_d;
    end
  end

  // Secondary components times the step length.
  p5_t p5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p5_q.sd     <= p4_q.sd;
      p5_q.prod_x <= 66'(mag32(p4_q.sd.ax)) * 66'(p4_q.s);
      p5_q.prod_y <= 66'(mag32(p4_q.sd.ay)) * 66'(p4_q.s);
    end
  end

  // Second divider: products over the secondary norm.
  dvl_t d2x0_d, d2y0_d;

  always_comb begin
    d2x0_d.rem = 32'(p5_q.prod_x >> Div2Steps);
    d2x0_d.num = p5_q.prod_x << (NumW - Div2Steps);
    d2x0_d.q   = '0;
    d2y0_d.rem = 32'(p5_q.prod_y >> Div2Steps);
    d2y0_d.num = p5_q.prod_y << (NumW - Div2Steps);
    d2y0_d.q   = '0;
  end

  dvl_t  d2x_q [Div2Steps+1];
  dvl_t  d2y_q [Div2Steps+1];
  side_t d2s_q [Div2Steps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d2x_q[0] <= d2x0_d;
      d2y_q[0] <= d2y0_d;
      d2s_q[0] <= p5_q.sd;
    end
  end

  for (genvar k = 0; k < Div2Steps; k++) begin : g_div2
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d2x_q[k+1] <= dv_step(d2x_q[k], d2s_q[k].root);
        d2y_q[k+1] <= dv_step(d2y_q[k], d2s_q[k].root);
        d2s_q[k+1] <= d2s_q[k];
      end
    end
  end

  // Final stage: in the scaled case, add the scaled secondary vector and saturate.
  res_t               p6_d, p6_q;
  side_t              fsd;
  logic signed [35:0] q2x_s, q2y_s;

  always_comb begin
    fsd   = d2s_q[Div2Steps];
    q2x_s = fsd.ax[31] ? -signed'(36'(d2x_q[Div2Steps].q)) : signed'(36'(d2x_q[Div2Steps].q));
    q2y_s = fsd.ay[31] ? -signed'(36'(d2y_q[Div2Steps].q)) : signed'(36'(d2y_q[Div2Steps].q));
    p6_d.case_taken = fsd.kase;
    if (fsd.kase == CaseScaled) begin
      p6_d.out_x = sat32(36'(fsd.base_x) + q2x_s);
      p6_d.out_y = sat32(36'(fsd.base_y) + q2y_s);
    end else begin
      p6_d.out_x = fsd.base_x;
      p6_d.out_y = fsd.base_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p6_q <= p6_d;
    end
  end

  assign res_o = p6_q;

  // Assertions.
  `PVSL_ASSERT_NEXT(a_stall_holds_valids, !en_i, $stable(vld_q), "valid bits moved in a stall")
  `PVSL_ASSERT_IMPLIES(a_cross_fits, vld_q[IdxP1] && p1_q.sd.kase == CaseScaled, p1_q.cmag[34:32] == 3'b000, "cross term exceeds 32 bits")
  `PVSL_ASSERT_IMPLIES(a_step_fits, vld_q[IdxP4] && p4_q.sd.kase == CaseScaled, p4_q.s[33] == 1'b0, "step length exceeds 33 bits")
  `PVSL_ASSERT_IMPLIES(a_quot_fits, vld_q[IdxD2L] && fsd.kase == CaseScaled, d2x_q[Div2Steps].q[34] == 1'b0 && d2y_q[Div2Steps].q[34] == 1'b0, "scaled term exceeds 34 bits")

endmodule

// File: rtl/prioritized_vector_sum_limit.sv
`timescale 1ns / 1ps
// ============================================================================
// Prioritized vector sum with magnitude limit
// Adds a secondary vector to a priority vector without exceeding a limit.
// ============================================================================
// Usage:
//   in_i carries one item per handshake: priority vector, secondary vector
//   and limit, all raw fixed point. out_o returns one result item per input
//   item, in order: the resulting vector, saturated to 32 bits, and the code
//   of the rule that produced it.
//   Items pass from the accepting edge to out_o.valid through two stages
//   of products, a decision stage, two 32-stage square roots, dividers of 34
//   and 35 stages (one quotient bit per stage) and a few glue stages, then
//   the output register.
//   Throughput is one item per cycle while the output is not stalled; the
//   one-bit-per-stage root and divide pipelines set the depth, not the rate.
//   Reset clears every valid bit; the pipeline is empty afterwards.
//   When the receiver stalls, a finished item waits in the output register
//   and the pipeline still moves as long as its last stage is empty; once
//   that stage holds an item too, the whole pipeline holds and in_i.ready
//   goes low until the output is taken.
// ============================================================================
module prioritized_vector_sum_limit #(
  parameter int unsigned FracBits = pvsl_pkg::FracBitsDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  pvsl_in_if.sink    in_i,
  pvsl_out_if.source out_o
);
  import pvsl_pkg::*;

  in_item_t item;
  res_t     dp_res;
  res_t     out_res_q;
  logic     dp_valid;
  logic     adv;
  logic     out_valid_q;

  // Item fields from the input channel.
  assign item.prio_x = in_i.prio_x;
  assign item.prio_y = in_i.prio_y;
  assign item.add_x  = in_i.add_x;
  assign item.add_y  = in_i.add_y;
  assign item.limit  = in_i.limit;

  // The pipeline moves unless its last item cannot go into the output register.
  assign adv        = !dp_valid || !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  pvsl_datapath #(
    .FracBits (FracBits)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_i.valid),
    .item_i  (item),
    .valid_o (dp_valid),
    .res_o   (dp_res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && dp_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && dp_valid) begin
      out_res_q <= dp_res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_x      = out_res_q.out_x;
  assign out_o.out_y      = out_res_q.out_y;
  assign out_o.case_taken = out_res_q.case_taken;

endmodule
